>>> rtl/framebuffer_line_circle_raster_defines.svh
// Assertion macros shared by the raster engine RTL.
// Depends on nothing; included by modules that assert.
`ifndef FRAMEBUFFER_LINE_CIRCLE_RASTER_DEFINES_SVH
`define FRAMEBUFFER_LINE_CIRCLE_RASTER_DEFINES_SVH
`define FLCR_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FLCR_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/flcr_pkg.sv
// Package for the line and circle raster engine: command codes, types.
// Depends on nothing.
package flcr_pkg;
  localparam int WidthDef  = 128;
  localparam int HeightDef = 64;

  typedef enum logic [2:0] {
    FN_CLEAR  = 3'd0,
    FN_PIXEL  = 3'd1,
    FN_LINE   = 3'd2,
    FN_CIRCLE = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [8:0] x_a;
    logic signed [8:0] y_a;
    logic signed [8:0] x_b;
    logic signed [8:0] y_b;
    logic [7:0]        radius;
    logic              ink;
    logic [9:0]        read_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_LINE, ST_CIRC, ST_RMW_RD, ST_RMW_WR, ST_READ, ST_DONE
  } st_t;
endpackage

>>> rtl/flcr_front.sv
// Command front end: takes commands and holds them in a two-entry queue.
// Depends on flcr_pkg.
module flcr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  flcr_pkg::cmd_t cmd_in,
  output logic           q_valid,
  output flcr_pkg::cmd_t q_cmd,
  input  logic           q_pop
);
  flcr_pkg::cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign busy    = cnt_r[1];
  assign push    = start && !busy;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd_in;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end
endmodule

>>> rtl/flcr_back.sv
// Raster back end: line and circle steppers, frame store read-modify-write.
// Depends on flcr_pkg and the assertion macro header.
`include "framebuffer_line_circle_raster_defines.svh"
module flcr_back #(
  parameter int WIDTH  = flcr_pkg::WidthDef,
  parameter int HEIGHT = flcr_pkg::HeightDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  flcr_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  output logic [7:0]     out_read_byte,
  output logic           out_was_read
);
  localparam int Bytes = WIDTH * HEIGHT / 8;
  localparam int Aw    = $clog2(Bytes);

  logic [7:0] mem [Bytes];
  logic [7:0] rdata_r;

  flcr_pkg::st_t st_r, st_nxt, ret_r, ret_nxt;
  flcr_pkg::cmd_t c_r, c_nxt;
  logic signed [11:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [11:0] dx_r, dx_nxt, dy_r, dy_nxt, err_r, err_nxt;
  logic signed [11:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [2:0] oct_r, oct_nxt;
  logic [Aw:0] clr_r, clr_nxt;
  logic [Aw-1:0] addr_r, addr_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic ov_r, ov_nxt, wr_r, wr_nxt;
  logic [7:0] rb_r, rb_nxt;

  logic we;
  logic [Aw-1:0] waddr, raddr;
  logic [7:0] wdata;

  logic signed [11:0] ox, oy, e2, tx, ty;
  logic onscr;
  logic [11:0] idx;

  always_comb begin
    unique case (oct_r)
      3'd0: begin ox =  cx_r; oy =  cy_r; end
      3'd1: begin ox =  cy_r; oy =  cx_r; end
      3'd2: begin ox = -cy_r; oy =  cx_r; end
      3'd3: begin ox = -cx_r; oy =  cy_r; end
      3'd4: begin ox = -cx_r; oy = -cy_r; end
      3'd5: begin ox = -cy_r; oy = -cx_r; end
      3'd6: begin ox =  cy_r; oy = -cx_r; end
      default: begin ox = cx_r; oy = -cy_r; end
    endcase
  end

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; c_nxt = c_r;
    px_nxt = px_r; py_nxt = py_r; dx_nxt = dx_r; dy_nxt = dy_r; err_nxt = err_r;
    cx_nxt = cx_r; cy_nxt = cy_r; oct_nxt = oct_r; clr_nxt = clr_r;
    addr_nxt = addr_r; bit_nxt = bit_r; ov_nxt = 1'b0; wr_nxt = wr_r; rb_nxt = rb_r;
    q_pop = 1'b0; we = 1'b0; waddr = addr_r; wdata = 8'd0; raddr = addr_r;
    e2 = err_r <<< 1;
    tx = (st_r == flcr_pkg::ST_CIRC) ? px_r + ox : px_r;
    ty = (st_r == flcr_pkg::ST_CIRC) ? py_r + oy : py_r;
    onscr = tx >= 0 && tx < 12'(WIDTH) && ty >= 0 && ty < 12'(HEIGHT);
    idx = 12'(ty >>> 3) * 12'(WIDTH) + 12'(tx);
    unique case (st_r)
      flcr_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          c_nxt = q_cmd;
          px_nxt = 12'(q_cmd.x_a);
          py_nxt = 12'(q_cmd.y_a);
          rb_nxt = 8'd0; wr_nxt = 1'b0;
          dx_nxt = (q_cmd.x_b > q_cmd.x_a) ? 12'(q_cmd.x_b) - 12'(q_cmd.x_a)
                                           : 12'(q_cmd.x_a) - 12'(q_cmd.x_b);
          dy_nxt = (q_cmd.y_b > q_cmd.y_a) ? 12'(q_cmd.y_a) - 12'(q_cmd.y_b)
                                           : 12'(q_cmd.y_b) - 12'(q_cmd.y_a);
          cx_nxt = 12'(q_cmd.radius); cy_nxt = '0; err_nxt = '0; oct_nxt = '0;
          clr_nxt = '0;
          unique case (q_cmd.func)
            flcr_pkg::FN_CLEAR:  begin st_nxt = flcr_pkg::ST_CLEAR;
              ret_nxt = flcr_pkg::ST_DONE; end
            flcr_pkg::FN_PIXEL:  begin st_nxt = flcr_pkg::ST_LINE;
              dx_nxt = '0; dy_nxt = '0; c_nxt.x_b = q_cmd.x_a; c_nxt.y_b = q_cmd.y_a; end
            flcr_pkg::FN_LINE:   st_nxt = flcr_pkg::ST_LINE;
            flcr_pkg::FN_CIRCLE: st_nxt = flcr_pkg::ST_CIRC;
            flcr_pkg::FN_READ:   begin wr_nxt = 1'b1;
              if (32'(q_cmd.read_index) < Bytes) begin
                addr_nxt = Aw'(q_cmd.read_index); st_nxt = flcr_pkg::ST_READ;
              end else st_nxt = flcr_pkg::ST_DONE;
            end
            default: st_nxt = flcr_pkg::ST_DONE;
          endcase
          if (q_cmd.func == flcr_pkg::FN_LINE || q_cmd.func == flcr_pkg::FN_PIXEL)
            err_nxt = ((q_cmd.x_b > q_cmd.x_a) ? 12'(q_cmd.x_b) - 12'(q_cmd.x_a)
                                               : 12'(q_cmd.x_a) - 12'(q_cmd.x_b))
                    + ((q_cmd.y_b > q_cmd.y_a) ? 12'(q_cmd.y_a) - 12'(q_cmd.y_b)
                                               : 12'(q_cmd.y_b) - 12'(q_cmd.y_a));
        end
      end
      flcr_pkg::ST_CLEAR: begin
        we = 1'b1; waddr = clr_r[Aw-1:0];
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == Bytes - 1) st_nxt = ret_r;
      end
      flcr_pkg::ST_LINE: begin
        if (px_r == 12'(c_r.x_b) && py_r == 12'(c_r.y_b)) ret_nxt = flcr_pkg::ST_DONE;
        else ret_nxt = flcr_pkg::ST_LINE;
        if (ret_nxt != flcr_pkg::ST_DONE) begin
          if (e2 >= dy_r) begin
            px_nxt = (c_r.x_a < c_r.x_b) ? px_r + 12'sd1 : px_r - 12'sd1;
          end
          if (e2 <= dx_r) begin
            py_nxt = (c_r.y_a < c_r.y_b) ? py_r + 12'sd1 : py_r - 12'sd1;
          end
          err_nxt = err_r + ((e2 >= dy_r) ? dy_r : 12'sd0) + ((e2 <= dx_r) ? dx_r : 12'sd0);
        end
        if (onscr) begin
          addr_nxt = Aw'(idx); bit_nxt = ty[2:0]; st_nxt = flcr_pkg::ST_RMW_RD;
        end else st_nxt = ret_nxt;
      end
      flcr_pkg::ST_CIRC: begin
        if (cx_r < cy_r) st_nxt = flcr_pkg::ST_DONE;
        else begin
          ret_nxt = flcr_pkg::ST_CIRC;
          oct_nxt = oct_r + 1'b1;
          if (oct_r == 3'd7) begin
            cy_nxt = cy_r + 12'sd1;
            if (err_r <= 0) err_nxt = err_r + (cy_r <<< 1) + 12'sd3;
            else begin
              cx_nxt = cx_r - 12'sd1;
              err_nxt = err_r - (cx_r <<< 1) + 12'sd1;
            end
          end
          if (onscr) begin
            addr_nxt = Aw'(idx); bit_nxt = ty[2:0]; st_nxt = flcr_pkg::ST_RMW_RD;
          end
        end
      end
      flcr_pkg::ST_RMW_RD: st_nxt = flcr_pkg::ST_RMW_WR;
      flcr_pkg::ST_RMW_WR: begin
        we = 1'b1;
        wdata = c_r.ink ? (rdata_r | (8'd1 << bit_r)) : (rdata_r & ~(8'd1 << bit_r));
        st_nxt = ret_r;
      end
      flcr_pkg::ST_READ: st_nxt = flcr_pkg::ST_DONE;
      flcr_pkg::ST_DONE: begin
        if (wr_r && c_r.func == flcr_pkg::FN_READ && 32'(c_r.read_index) < Bytes)
          rb_nxt = rdata_r;
        ov_nxt = 1'b1;
        st_nxt = flcr_pkg::ST_IDLE;
      end
      default: st_nxt = flcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt; px_r <= px_nxt; py_r <= py_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt;
    err_r <= err_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt; oct_r <= oct_nxt;
    addr_r <= addr_nxt; bit_r <= bit_nxt; rb_r <= rb_nxt; wr_r <= wr_nxt;
    if (!rst_n) begin
      st_r <= flcr_pkg::ST_CLEAR;
      ret_r <= flcr_pkg::ST_IDLE;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ret_r <= ret_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_read_byte = rb_r;
  assign out_was_read  = ov_r && wr_r;

  `FLCR_ASSERT_NXT(a_done_out, clk, rst_n, st_r == flcr_pkg::ST_DONE, out_valid)
  `FLCR_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == flcr_pkg::ST_IDLE)
  `FLCR_ASSERT_NXT(a_rmw, clk, rst_n, st_r == flcr_pkg::ST_RMW_RD, st_r == flcr_pkg::ST_RMW_WR)
endmodule

>>> rtl/framebuffer_line_circle_raster.sv
// Top level of the line and circle raster engine with its page-layout frame store.
// Depends on flcr_pkg, flcr_front and flcr_back.
// One result per command, shown for one cycle with out_valid; it cannot be held
// off. Commands queue two deep; busy is high when the queue is full. After reset
// the store is cleared, one byte a cycle, before the first command runs. Each
// plotted on-screen pixel costs one read-modify-write of the store (states
// ST_RMW_RD, then ST_RMW_WR); a skipped pixel costs no access. A clear command
// writes the store one byte a cycle.
module framebuffer_line_circle_raster #(
  parameter int WIDTH  = flcr_pkg::WidthDef,
  parameter int HEIGHT = flcr_pkg::HeightDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_func,
  input  logic signed [8:0] in_x_a,
  input  logic signed [8:0] in_y_a,
  input  logic signed [8:0] in_x_b,
  input  logic signed [8:0] in_y_b,
  input  logic [7:0]        in_radius,
  input  logic              in_ink,
  input  logic [9:0]        in_read_index,
  output logic              out_valid,
  output logic [7:0]        out_read_byte,
  output logic              out_was_read
);
  flcr_pkg::cmd_t cmd_in, q_cmd;
  logic q_valid, q_pop;

  assign cmd_in = '{func: in_func, x_a: in_x_a, y_a: in_y_a, x_b: in_x_b,
                    y_b: in_y_b, radius: in_radius, ink: in_ink,
                    read_index: in_read_index};

  flcr_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  flcr_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_read_byte(out_read_byte), .out_was_read(out_was_read)
  );
endmodule
